### hdl/signed_manifest_header_parser_core_assert.svh
// Assertion macros for the manifest parser.
// Used by the queue and top level; no other dependencies.
`ifndef SIGNED_MANIFEST_HEADER_PARSER_CORE_ASSERT_SVH
`define SIGNED_MANIFEST_HEADER_PARSER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SMH_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SMH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SMH_ASSERT_IMP(label, clk, rst, ante, cons)
`define SMH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hdl/smh_pkg.sv
// Shared types and constants for the manifest parser.
// No dependencies.
`timescale 1ns / 1ps
package smh_pkg;
   localparam int unsigned HDR_BYTES = 64;
   localparam int unsigned ENT_BYTES = 128;
   localparam int unsigned ENT_RSV_START = 112;
   localparam int unsigned MIN_COUNT = 3;
   localparam logic [13:0] OFFSET_MAX = 14'h3fff;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_FORMAT = 3'd1;
   localparam logic [2:0] ST_ROLLBACK = 3'd2;
   localparam logic [2:0] ST_TARGET = 3'd3;
   localparam logic [2:0] ST_BAD_LENGTH = 3'd4;

   localparam logic [2:0] REG_MIN_EPOCH = 3'd0;
   localparam logic [2:0] REG_TARGET = 3'd1;
   localparam logic [2:0] REG_ROLE_CFG = 3'd2;
   localparam logic [2:0] REG_ROLE_CORE = 3'd3;
   localparam logic [2:0] REG_ROLE_SVC = 3'd4;
   localparam logic [2:0] REG_CFG_MAX = 3'd5;
   localparam logic [2:0] REG_IMG_MAX = 3'd6;

   function automatic logic [7:0] magic_byte(input logic [3:0] i);
      logic [7:0] m;
      begin
         case (i)
            4'd0: m = 8'h56;  4'd1: m = 8'h53;  4'd2: m = 8'h4B;  4'd3: m = 8'h2D;
            4'd4: m = 8'h42;  4'd5: m = 8'h55;  4'd6: m = 8'h4E;  4'd7: m = 8'h44;
            4'd8: m = 8'h4C;  4'd9: m = 8'h45;  4'd10: m = 8'h2D; 4'd11: m = 8'h76;
            4'd12: m = 8'h31; default: m = 8'h00;
         endcase
         return m;
      end
   endfunction

   // Classified work handed from the front to the back.
   typedef struct packed {
      logic         ent_done;   // an entry completed on this item
      logic [6:0]   ent_num;
      logic [31:0]  role;
      logic [31:0]  inst;
      logic [63:0]  len;
      logic         rsv_bad;
      logic [31:0]  prev_inst;
      logic         fin;        // item is last
      logic [13:0]  total;
      logic         hdr_fmt_bad; // header checks not involving config
      logic [63:0]  epoch;
      logic [31:0]  tmajor;
      logic [6:0]   count_sat;
   } work_type;

   typedef struct packed {
      logic         rec_type;
      logic [2:0]   status;
      logic [5:0]   entry_index;
      logic [31:0]  role;
      logic [31:0]  inst;
      logic [63:0]  len;
      logic [63:0]  epoch;
      logic [6:0]   count;
   } rec_type;
endpackage

### hdl/smh_front.sv
// Front part: takes bytes, stores the header, accumulates entry fields.
// Depends on smh_pkg.
`timescale 1ns / 1ps
module smh_front import smh_pkg::*; #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] data_byte,
   input  logic       last,
   output work_type   work
);
   logic [13:0] off_ff;
   logic [6:0]  num_ff;
   logic [31:0] role_ff, inst_ff, prev_ff;
   logic [63:0] len_ff;
   logic        rsv_ff;
   logic [7:0]  hdr_ff [HDR_BYTES];
   logic [7:0]  hb [HDR_BYTES];

   logic        in_hdr, in_ent;
   logic [6:0]  pos;
   logic [31:0] role_in, inst_in;
   logic [63:0] len_in;
   logic        rsv_in;
   logic [13:0] off_in;
   logic        fmt;
   logic [31:0] cnt;
   logic [13:0] exp_total;
   logic [7:0]  zacc;

   assign in_hdr = off_ff < 14'(HDR_BYTES);
   assign in_ent = !in_hdr && (num_ff < 7'(MAX_ENTRIES));
   assign pos = 7'(off_ff - 14'(HDR_BYTES));
   assign off_in = (off_ff < OFFSET_MAX) ? off_ff + 14'd1 : off_ff;

   always_comb begin
      role_in = (pos == 7'd0) ? 32'd0 : role_ff;
      inst_in = (pos == 7'd0) ? 32'd0 : inst_ff;
      len_in = (pos == 7'd0) ? 64'd0 : len_ff;
      rsv_in = (pos == 7'd0) ? 1'b0 : rsv_ff;
      if (pos < 7'd4) role_in[8*pos[1:0] +: 8] = data_byte;
      else if (pos < 7'd8) inst_in[8*pos[1:0] +: 8] = data_byte;
      else if (pos < 7'd16) len_in[8*pos[2:0] +: 8] = data_byte;
      else if (pos >= 7'(ENT_RSV_START) && data_byte != 8'd0) rsv_in = 1'b1;
   end

   // Header view including the current byte when it lands in the header.
   always_comb begin
      for (int i = 0; i < HDR_BYTES; i++)
         hb[i] = (in_hdr && off_ff[5:0] == 6'(i)) ? data_byte : hdr_ff[i];
   end

   always_comb begin
      fmt = 1'b0;
      for (int i = 0; i < 16; i++) if (hb[i] != magic_byte(4'(i))) fmt = 1'b1;
      if ({hb[17], hb[16]} != 16'd1 || {hb[19], hb[18]} != 16'd64 ||
          {hb[21], hb[20]} != 16'd128 || {hb[23], hb[22]} != 16'd1) fmt = 1'b1;
      if ({hb[27], hb[26], hb[25], hb[24]} != {18'd0, off_in}) fmt = 1'b1;
      zacc = 8'd0;
      for (int i = 32; i < 40; i++) zacc |= hb[i];
      for (int i = 52; i < 64; i++) zacc |= hb[i];
      if (zacc != 8'd0) fmt = 1'b1;
      cnt = {hb[31], hb[30], hb[29], hb[28]};
      exp_total = 14'(HDR_BYTES) + {cnt[6:0], 7'd0};
      if (cnt < 32'(MIN_COUNT) || cnt > 32'(MAX_ENTRIES) || off_in != exp_total) fmt = 1'b1;
      if ({hb[47], hb[46], hb[45], hb[44], hb[43], hb[42], hb[41], hb[40]} == 64'd0)
         fmt = 1'b1;
   end

   always_comb begin
      work.ent_done = take && in_ent && pos == 7'(ENT_BYTES - 1);
      work.ent_num = num_ff;
      work.role = role_in;
      work.inst = inst_in;
      work.len = len_in;
      work.rsv_bad = rsv_in;
      work.prev_inst = prev_ff;
      work.fin = take && last;
      work.total = off_in;
      work.hdr_fmt_bad = fmt;
      work.epoch = {hb[47], hb[46], hb[45], hb[44], hb[43], hb[42], hb[41], hb[40]};
      work.tmajor = {hb[51], hb[50], hb[49], hb[48]};
      work.count_sat = (cnt > 32'd127) ? 7'd127 : cnt[6:0];
   end

   always_ff @(posedge clock) begin
      if (take && in_hdr) hdr_ff[off_ff[5:0]] <= data_byte;
      if (take && in_ent) begin
         role_ff <= role_in;
         inst_ff <= inst_in;
         len_ff <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff <= '0; num_ff <= '0; rsv_ff <= 1'b0; prev_ff <= '0;
      end else if (take) begin
         if (last) begin
            off_ff <= '0; num_ff <= '0; rsv_ff <= 1'b0; prev_ff <= '0;
         end else begin
            off_ff <= off_in;
            if (in_ent) rsv_ff <= rsv_in;
            if (work.ent_done) begin
               num_ff <= num_ff + 7'd1;
               prev_ff <= inst_in;
            end
         end
      end
   end
endmodule

### hdl/smh_queue.sv
// Short work queue between front and back parts.
// Depends on smh_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "signed_manifest_header_parser_core_assert.svh"
module smh_queue import smh_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_data,
   output logic     has_room,
   input  logic     pop,
   output logic     not_empty,
   output work_type pop_data
);
   work_type    mem_ff [4];
   logic [1:0]  wp_ff, rp_ff;
   logic [2:0]  cnt_ff;

   assign has_room = cnt_ff < 3'd3; // one spare slot keeps ready registered-friendly
   assign not_empty = cnt_ff != 3'd0;
   assign pop_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 2'd1;
         if (pop) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(push) - 3'(pop);
      end
   end

   `SMH_ASSERT_IMP(a_no_under, clock, reset, pop, not_empty)
   `SMH_ASSERT_IMP(a_no_over, clock, reset, push, cnt_ff < 3'd4)
   `SMH_ASSERT_NEXT(a_cnt, clock, reset, push && !pop, cnt_ff == $past(cnt_ff) + 3'd1)
endmodule

### hdl/smh_back.sv
// Back part: runs entry and final checks, emits up to two records per work item.
// Depends on smh_pkg.
`timescale 1ns / 1ps
module smh_back import smh_pkg::*; #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  work_type    q_data,
   output logic        q_pop,
   input  logic [63:0] min_epoch,
   input  logic [31:0] tgt_major,
   input  logic [31:0] role_cfg,
   input  logic [31:0] role_core,
   input  logic [31:0] role_svc,
   input  logic [63:0] cfg_max,
   input  logic [63:0] img_max,
   output logic        out_valid,
   input  logic        out_ready,
   output rec_type     out_rec
);
   logic     err_ff;
   logic     half_ff; // entry record of current item already sent
   logic     full_ff;
   rec_type  rec_ff;
   logic     bad;
   logic     err_now;
   logic [2:0] st;
   logic     need_ent, need_fin, send_ent, load;
   rec_type  nxt;

   always_comb begin
      bad = q_data.rsv_bad || q_data.len == 64'd0;
      if (q_data.ent_num == 7'd0)
         bad = bad || q_data.role != role_cfg || q_data.inst != 32'd0 || q_data.len > cfg_max;
      else if (q_data.ent_num == 7'd1)
         bad = bad || q_data.role != role_core || q_data.inst != 32'd0 ||
               q_data.len > img_max;
      else
         bad = bad || q_data.role != role_svc || q_data.inst < 32'd1 ||
               q_data.inst > 32'd64 || q_data.len > img_max ||
               (q_data.ent_num > 7'd2 && q_data.inst <= q_data.prev_inst);
   end

   assign need_ent = q_data.ent_done && !half_ff;
   assign need_fin = q_data.fin;
   assign err_now = err_ff || (q_data.ent_done && bad);

   always_comb begin
      if (q_data.total < 14'(HDR_BYTES) ||
          32'(q_data.total) > 32'(HDR_BYTES) + 32'(MAX_ENTRIES) * 32'(ENT_BYTES))
         st = ST_BAD_LENGTH;
      else if (q_data.hdr_fmt_bad) st = ST_FORMAT;
      else if (q_data.epoch < min_epoch) st = ST_ROLLBACK;
      else if (q_data.tmajor != tgt_major) st = ST_TARGET;
      else if (err_now) st = ST_FORMAT;
      else st = ST_OK;
   end

   assign load = !full_ff || out_ready;
   assign send_ent = need_ent;
   // pop once the item's last record is loaded
   assign q_pop = q_valid && load && (!(need_ent && need_fin)) &&
                  (need_ent || need_fin || !q_data.ent_done || half_ff);

   always_comb begin
      nxt = '0;
      if (send_ent) begin
         nxt.status = bad ? ST_FORMAT : ST_OK;
         nxt.entry_index = q_data.ent_num[5:0];
         nxt.role = q_data.role;
         nxt.inst = q_data.inst;
         nxt.len = q_data.len;
      end else begin
         nxt.rec_type = 1'b1;
         nxt.status = st;
         if (st != ST_BAD_LENGTH) begin
            nxt.epoch = q_data.epoch;
            nxt.count = q_data.count_sat;
         end
      end
   end

   assign out_valid = full_ff;
   assign out_rec = rec_ff;

   always_ff @(posedge clock) begin
      if (load && q_valid && (need_ent || need_fin)) rec_ff <= nxt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0; half_ff <= 1'b0; err_ff <= 1'b0;
      end else begin
         if (load) full_ff <= q_valid && (need_ent || need_fin);
         if (q_valid && load) begin
            half_ff <= need_ent && need_fin;
            if (q_pop) half_ff <= 1'b0;
            if (need_ent && bad) err_ff <= 1'b1;
            if (q_pop && need_fin) err_ff <= 1'b0;
         end
      end
   end
endmodule

### hdl/signed_manifest_header_parser_core.sv
// Top level of the streaming manifest parser.
// Depends on smh_pkg, smh_front, smh_queue, smh_back and the assertion header.
`timescale 1ns / 1ps
`include "signed_manifest_header_parser_core_assert.svh"
// Usage:
// - req_ channel: one manifest byte per item, req_last on the final byte.
// - rsp_ channel: entry records (rsp_record_type 0) as each 128-byte entry
//   completes, and one final status record (rsp_record_type 1) per manifest.
// - csr_ port: write-only registers, index per the register list; write only
//   while idle.
// Throughput: one byte per cycle while the queue has room. The front classifies
// each byte in the cycle it is accepted; a 4-slot queue decouples it from the
// back, which checks and registers results. A byte that both closes an entry
// and ends the manifest yields two records, which the back sends in turn.
// Each record passes through a queue slot and then the back's output register
// before the receiver sees it.
// Reset clears run state and loads register defaults; the header store is
// only written, never cleared. When rsp_ready is low the output register
// holds, the queue fills, and req_ready drops once it has no room.
module signed_manifest_header_parser_core import smh_pkg::*; #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_record_type,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_entry_index,
   output logic [31:0] rsp_role,
   output logic [31:0] rsp_instance_res,
   output logic [63:0] rsp_blob_length,
   output logic [63:0] rsp_release_epoch,
   output logic [6:0]  rsp_entry_count,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   logic [63:0] min_epoch_ff, cfg_max_ff, img_max_ff;
   logic [31:0] tgt_ff, rcfg_ff, rcore_ff, rsvc_ff;
   logic        take, room, q_ne, q_pop;
   work_type    fw, qw;
   rec_type     rec;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_epoch_ff <= 64'd1; tgt_ff <= 32'd26; rcfg_ff <= 32'd0;
         rcore_ff <= 32'd1; rsvc_ff <= 32'd2; cfg_max_ff <= 64'd65536;
         img_max_ff <= 64'd16777216;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MIN_EPOCH: min_epoch_ff <= csr_wdata;
            REG_TARGET:    tgt_ff <= csr_wdata[31:0];
            REG_ROLE_CFG:  rcfg_ff <= csr_wdata[31:0];
            REG_ROLE_CORE: rcore_ff <= csr_wdata[31:0];
            REG_ROLE_SVC:  rsvc_ff <= csr_wdata[31:0];
            REG_CFG_MAX:   cfg_max_ff <= csr_wdata;
            REG_IMG_MAX:   img_max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_ready = room;
   assign take = req_valid && req_ready;

   smh_front #(.MAX_ENTRIES(MAX_ENTRIES)) u_front (
      .clock, .reset, .take, .data_byte(req_data_byte), .last(req_last), .work(fw)
   );

   // only bytes that produce a record enter the queue
   smh_queue u_queue (
      .clock, .reset, .push(take && (fw.ent_done || fw.fin)), .push_data(fw),
      .has_room(room), .pop(q_pop), .not_empty(q_ne), .pop_data(qw)
   );

   smh_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
      .clock, .reset, .q_valid(q_ne), .q_data(qw), .q_pop,
      .min_epoch(min_epoch_ff), .tgt_major(tgt_ff), .role_cfg(rcfg_ff),
      .role_core(rcore_ff), .role_svc(rsvc_ff), .cfg_max(cfg_max_ff),
      .img_max(img_max_ff), .out_valid(rsp_valid), .out_ready(rsp_ready),
      .out_rec(rec)
   );

   assign rsp_record_type = rec.rec_type;
   assign rsp_status = rec.status;
   assign rsp_entry_index = rec.entry_index;
   assign rsp_role = rec.role;
   assign rsp_instance_res = rec.inst;
   assign rsp_blob_length = rec.len;
   assign rsp_release_epoch = rec.epoch;
   assign rsp_entry_count = rec.count;

   `SMH_ASSERT_IMP(a_status_range, clock, reset, rsp_valid, rsp_status <= ST_BAD_LENGTH)
   `SMH_ASSERT_IMP(a_entry_ok_fmt, clock, reset, rsp_valid && !rsp_record_type,
                   rsp_status == ST_OK || rsp_status == ST_FORMAT)
   `SMH_ASSERT_IMP(a_badlen_zero, clock, reset,
                   rsp_valid && rsp_record_type && rsp_status == ST_BAD_LENGTH,
                   rsp_release_epoch == 64'd0 && rsp_entry_count == 7'd0)
endmodule

### bench/signed_manifest_header_parser_core_test.sv
// Self-checking bench for signed_manifest_header_parser_core: byte stream in, records out.
// Depends on smh_pkg and the DUT; predicts every record and compares field by field.
`timescale 1ns / 1ps
module signed_manifest_header_parser_core_test;
   import smh_pkg::*;

   localparam int MAX_ENT = 64;
   localparam int unsigned CYCLE_LIMIT = 900000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_last;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_record_type;
   logic [2:0]  rsp_status;
   logic [5:0]  rsp_entry_index;
   logic [31:0] rsp_role;
   logic [31:0] rsp_instance_res;
   logic [63:0] rsp_blob_length;
   logic [63:0] rsp_release_epoch;
   logic [6:0]  rsp_entry_count;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;

   signed_manifest_header_parser_core #(.MAX_ENTRIES(MAX_ENT)) dut (.*);

   // current register image
   logic [63:0] min_epoch_q, cfg_max_q, img_max_q;
   logic [31:0] target_q, role_cfg_q, role_core_q, role_svc_q;

   // predictor state
   logic [7:0]  hdr_mem [64];
   logic [13:0] p_offset;
   logic [6:0]  p_entry;
   logic [31:0] p_role, p_inst, p_prev_inst;
   logic [63:0] p_len;
   logic        p_rsv_bad, p_entry_bad_seen;

   rec_type     record_q [$];
   logic [7:0]  mbytes [$];

   int          errors = 0;
   int          records_seen = 0;
   int          bytes_sent = 0;
   int          manifests_sent = 0;
   int          send_idle = 0;
   int          rsp_idle = 0;
   int unsigned cycles = 0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d records pending", cycles, record_q.size());
         $display("signed_manifest_header_parser_core regression: fail");
         $finish;
      end
   end

   // receiver: random back-pressure per phase
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle);
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      errors++;
      $display("mismatch %s: got %0h expected %0h (record %0d)", what, got, want, records_seen);
   endtask

   // sampled at the falling edge so the values are settled; accepted at the next rise
   always @(negedge clock) begin
      rec_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (record_q.size() == 0) begin
            report("unexpected record", {57'd0, rsp_status, rsp_record_type, 3'd0}, 64'd0);
         end else begin
            want = record_q.pop_front();
            if (rsp_record_type !== want.rec_type) report("record_type", rsp_record_type, want.rec_type);
            if (rsp_status !== want.status) report("status", rsp_status, want.status);
            if (rsp_entry_index !== want.entry_index)
               report("entry_index", rsp_entry_index, want.entry_index);
            if (rsp_role !== want.role) report("role", rsp_role, want.role);
            if (rsp_instance_res !== want.inst) report("instance_res", rsp_instance_res, want.inst);
            if (rsp_blob_length !== want.len) report("blob_length", rsp_blob_length, want.len);
            if (rsp_release_epoch !== want.epoch)
               report("release_epoch", rsp_release_epoch, want.epoch);
            if (rsp_entry_count !== want.count) report("entry_count", rsp_entry_count, want.count);
         end
         records_seen++;
      end
   end

   // ---------------- predictor ----------------
   function automatic logic [31:0] hdr_word(input int at);
      return {hdr_mem[at+3], hdr_mem[at+2], hdr_mem[at+1], hdr_mem[at]};
   endfunction

   function automatic logic [15:0] hdr_half(input int at);
      return {hdr_mem[at+1], hdr_mem[at]};
   endfunction

   function automatic logic [63:0] hdr_dword(input int at);
      return {hdr_word(at + 4), hdr_word(at)};
   endfunction

   function automatic logic entry_is_bad();
      if (p_rsv_bad || p_len == 0) return 1'b1;
      if (p_entry == 0) return p_role != role_cfg_q || p_inst != 0 || p_len > cfg_max_q;
      if (p_entry == 1) return p_role != role_core_q || p_inst != 0 || p_len > img_max_q;
      if (p_role != role_svc_q || p_inst < 1 || p_inst > 64 || p_len > img_max_q) return 1'b1;
      return p_entry > 2 && p_inst <= p_prev_inst;
   endfunction

   function automatic logic [2:0] manifest_status(input int unsigned total);
      logic [63:0] cnt;
      logic        fmt_bad;
      if (total < HDR_BYTES || total > HDR_BYTES + MAX_ENT * ENT_BYTES) return ST_BAD_LENGTH;
      cnt = {32'd0, hdr_word(28)};
      fmt_bad = 1'b0;
      for (int i = 0; i < 16; i++) if (hdr_mem[i] != magic_byte(i[3:0])) fmt_bad = 1'b1;
      for (int i = 32; i < 40; i++) if (hdr_mem[i] != 0) fmt_bad = 1'b1;
      for (int i = 52; i < 64; i++) if (hdr_mem[i] != 0) fmt_bad = 1'b1;
      if (hdr_half(16) != 1 || hdr_half(18) != 64 || hdr_half(20) != 128 || hdr_half(22) != 1)
         fmt_bad = 1'b1;
      if (hdr_word(24) != total || cnt < MIN_COUNT || cnt > MAX_ENT) fmt_bad = 1'b1;
      if (64'(total) != 64'(HDR_BYTES) + cnt * ENT_BYTES || hdr_dword(40) == 0) fmt_bad = 1'b1;
      if (fmt_bad) return ST_FORMAT;
      if (hdr_dword(40) < min_epoch_q) return ST_ROLLBACK;
      if (hdr_word(48) != target_q) return ST_TARGET;
      if (p_entry_bad_seen) return ST_FORMAT;
      return ST_OK;
   endfunction

   task automatic clear_run_state();
      p_offset = 0;
      p_entry = 0;
      p_role = 0;
      p_inst = 0;
      p_len = 0;
      p_rsv_bad = 0;
      p_prev_inst = 0;
      p_entry_bad_seen = 0;
   endtask

   task automatic absorb_byte(input logic [7:0] b, input logic l);
      int unsigned pos;
      rec_type r;
      logic bad;
      logic [31:0] c;
      if (p_offset < HDR_BYTES) begin
         hdr_mem[p_offset] = b;
      end else if (p_entry < MAX_ENT) begin
         pos = (p_offset - HDR_BYTES) & (ENT_BYTES - 1);
         if (pos == 0) begin
            p_role = 0; p_inst = 0; p_len = 0; p_rsv_bad = 0;
         end
         if (pos < 4) p_role[8*pos +: 8] = b;
         else if (pos < 8) p_inst[8*(pos-4) +: 8] = b;
         else if (pos < 16) p_len[8*(pos-8) +: 8] = b;
         else if (pos >= ENT_RSV_START && b != 0) p_rsv_bad = 1'b1;
         if (pos == ENT_BYTES - 1) begin
            bad = entry_is_bad();
            r = '0;
            r.status = bad ? ST_FORMAT : ST_OK;
            r.entry_index = p_entry[5:0];
            r.role = p_role;
            r.inst = p_inst;
            r.len = p_len;
            record_q.push_back(r);
            if (bad) p_entry_bad_seen = 1'b1;
            p_prev_inst = p_inst;
            p_entry++;
         end
      end
      if (p_offset < OFFSET_MAX) p_offset++;
      if (l) begin
         r = '0;
         r.rec_type = 1'b1;
         r.status = manifest_status(p_offset);
         if (r.status != ST_BAD_LENGTH) begin
            c = hdr_word(28);
            r.epoch = hdr_dword(40);
            r.count = (c > 127) ? 7'd127 : c[6:0];
         end
         record_q.push_back(r);
         clear_run_state();
      end
   endtask

   // ---------------- driving ----------------
   // called at a rising edge; returns at the edge that accepts the item
   task automatic send_byte(input logic [7:0] b, input logic l);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last <= l;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      absorb_byte(b, l);
      bytes_sent++;
   endtask

   task automatic send_manifest();
      for (int i = 0; i < mbytes.size(); i++) send_byte(mbytes[i], i == mbytes.size() - 1);
      manifests_sent++;
   endtask

   // wait until all records are in, then let anything still in the pipe settle
   task automatic drain();
      req_valid <= 1'b0;
      while (record_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         REG_MIN_EPOCH: min_epoch_q = val;
         REG_TARGET:    target_q = val[31:0];
         REG_ROLE_CFG:  role_cfg_q = val[31:0];
         REG_ROLE_CORE: role_core_q = val[31:0];
         REG_ROLE_SVC:  role_svc_q = val[31:0];
         REG_CFG_MAX:   cfg_max_q = val;
         REG_IMG_MAX:   img_max_q = val;
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [63:0] mine, input logic [31:0] tgt, input logic [31:0] rc,
                            input logic [31:0] rk, input logic [31:0] rs, input logic [63:0] cmax,
                            input logic [63:0] imax);
      write_reg(REG_MIN_EPOCH, mine);
      write_reg(REG_TARGET, {32'd0, tgt});
      write_reg(REG_ROLE_CFG, {32'd0, rc});
      write_reg(REG_ROLE_CORE, {32'd0, rk});
      write_reg(REG_ROLE_SVC, {32'd0, rs});
      write_reg(REG_CFG_MAX, cmax);
      write_reg(REG_IMG_MAX, imax);
   endtask

   // ---------------- manifest construction ----------------
   task automatic put_le(input int at, input logic [63:0] val, input int n);
      for (int i = 0; i < n; i++) mbytes[at + i] = val[8*i +: 8];
   endtask

   function automatic logic [63:0] pick_length(input logic [63:0] cap);
      case ($urandom_range(7))
         0: return cap;
         1: return 64'd1;
         default: return 64'd1 + rand64() % cap;
      endcase
   endfunction

   // manifest for the current registers, random content; well-formed up to 23 entries
   task automatic build_manifest(input int cnt);
      int unsigned total;
      logic [63:0] ep;
      logic [31:0] inst;
      int base;
      total = HDR_BYTES + cnt * ENT_BYTES;
      mbytes.delete();
      for (int i = 0; i < total; i++) mbytes.push_back(8'h00);
      for (int i = 0; i < 16; i++) mbytes[i] = magic_byte(i[3:0]);
      put_le(16, 1, 2);
      put_le(18, 64, 2);
      put_le(20, 128, 2);
      put_le(22, 1, 2);
      put_le(24, total, 4);
      put_le(28, cnt, 4);
      ep = ($urandom_range(1)) ? rand64() : 64'($urandom_range(1, 8));
      if (ep < min_epoch_q) ep = min_epoch_q;
      if (ep == 0) ep = 64'd1;
      put_le(40, ep, 8);
      put_le(48, {32'd0, target_q}, 4);
      inst = 0;
      for (int k = 0; k < cnt; k++) begin
         base = HDR_BYTES + k * ENT_BYTES;
         if (k >= 2) inst = inst + $urandom_range(1, 3);
         put_le(base, {32'd0, k == 0 ? role_cfg_q : (k == 1 ? role_core_q : role_svc_q)}, 4);
         put_le(base + 4, {32'd0, inst}, 4);
         put_le(base + 8, pick_length(k == 0 ? cfg_max_q : img_max_q), 8);
         for (int p = 16; p < ENT_RSV_START; p++) mbytes[base + p] = $urandom;
      end
   endtask

   // one random flaw; some land in digest bytes and change nothing
   task automatic corrupt_manifest();
      int at;
      case ($urandom_range(6))
         0: begin
            at = $urandom_range(mbytes.size() - 1);
            mbytes[at] = mbytes[at] ^ 8'($urandom_range(1, 255));
         end
         1: repeat ($urandom_range(1, 130)) if (mbytes.size() > 1) void'(mbytes.pop_back());
         2: repeat ($urandom_range(1, 130)) mbytes.push_back($urandom);
         3: put_le(28, $urandom_range(0, 70), 4);
         4: if (min_epoch_q != 0) put_le(40, min_epoch_q - 1, 8);
         5: put_le(48, {32'd0, ~target_q}, 4);
         default: begin
            at = HDR_BYTES + ENT_BYTES * $urandom_range(0, 2) + $urandom_range(0, 15);
            mbytes[at] = $urandom;
         end
      endcase
   endtask

   // ---------------- tests ----------------
   task automatic test_defaults_and_header_checks();
      build_manifest(3);
      send_manifest();                          // clean manifest, all ok
      build_manifest(4);
      put_le(40, 0, 8);                         // epoch below reset minimum
      send_manifest();
      build_manifest(3);
      put_le(48, 27, 4);                        // wrong target major
      send_manifest();
      build_manifest(3);
      put_le(24, 1, 4);                         // declared length off
      put_le(48, 27, 4);                        // format beats target
      send_manifest();
      mbytes.delete();
      repeat (10) mbytes.push_back($urandom);   // far too short
      send_manifest();
      build_manifest(3);
      mbytes = mbytes[0:62];                    // one byte short of a header
      send_manifest();
      build_manifest(3);
      mbytes = mbytes[0:63];                    // header only
      send_manifest();
      mbytes.delete();
      mbytes.push_back(8'hff);                  // single byte manifest
      send_manifest();
      drain();
   endtask

   task automatic test_entry_checks();
      build_manifest(7);
      mbytes[HDR_BYTES + ENT_RSV_START] = 8'h01;               // reserved byte set
      put_le(HDR_BYTES + ENT_BYTES + 0, {32'd0, ~role_core_q}, 4); // wrong role
      put_le(HDR_BYTES + 2 * ENT_BYTES + 4, 0, 4);             // service instance zero
      put_le(HDR_BYTES + 3 * ENT_BYTES + 4, 65, 4);            // instance over 64
      put_le(HDR_BYTES + 4 * ENT_BYTES + 4, 65, 4);            // not increasing
      put_le(HDR_BYTES + 5 * ENT_BYTES + 8, 0, 8);             // zero length
      put_le(HDR_BYTES + 6 * ENT_BYTES + 8, img_max_q + 1, 8); // too long
      send_manifest();
      build_manifest(3);
      put_le(HDR_BYTES + 4, 1, 4);                             // config instance nonzero
      put_le(HDR_BYTES + 8, cfg_max_q + 1, 8);
      send_manifest();
      drain();
   endtask

   task automatic test_size_limits();
      build_manifest(MAX_ENT);                  // largest manifest size allowed
      send_manifest();
      build_manifest(MAX_ENT);
      repeat (ENT_BYTES) mbytes.push_back($urandom); // one entry too many
      send_manifest();
      mbytes.delete();
      repeat (int'(OFFSET_MAX) + 20) mbytes.push_back(8'h00); // offset saturates
      send_manifest();
      drain();
   endtask

   task automatic test_register_extremes();
      write_all(64'd0, 32'hffffffff, 32'hffffffff, 32'd0, 32'h80000000,
                64'hffffffffffffffff, 64'd1);
      build_manifest(3);
      send_manifest();
      build_manifest(3);
      put_le(HDR_BYTES + ENT_BYTES + 8, 2, 8);
      send_manifest();
      drain();
      write_all(64'hffffffffffffffff, 32'd0, 32'd7, 32'd7, 32'd7, 64'd1, 64'hffffffffffffffff);
      build_manifest(4);
      send_manifest();
      build_manifest(3);
      put_le(40, 64'hfffffffffffffffe, 8);
      send_manifest();
      drain();
   endtask

   task automatic test_random(input int snd, input int rcv, input int byte_budget);
      int start_bytes, start_recs;
      drain();
      write_all(($urandom_range(3) == 0) ? rand64() : 64'($urandom_range(0, 3)), $urandom,
                $urandom, $urandom, $urandom,
                ($urandom_range(1)) ? rand64() | 64'd1 : 64'($urandom_range(1, 1 << 20)),
                ($urandom_range(1)) ? rand64() | 64'd1 : 64'($urandom_range(1, 1 << 24)));
      send_idle = snd;
      rsp_idle = rcv;
      start_bytes = bytes_sent;
      start_recs = records_seen;
      while (bytes_sent - start_bytes < byte_budget || records_seen - start_recs < 25) begin
         if ($urandom_range(9) < 8) begin
            build_manifest(($urandom_range(7) == 0) ? $urandom_range(3, 12) : $urandom_range(3, 4));
            if ($urandom_range(9) < 4) corrupt_manifest();
         end else begin
            mbytes.delete();
            repeat ($urandom_range(1, 80)) mbytes.push_back($urandom);
         end
         send_manifest();
      end
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'h00;
      req_last = 1'b0;
      csr_write = 1'b0;
      csr_index = REG_MIN_EPOCH;
      csr_wdata = 64'd0;
      for (int i = 0; i < 64; i++) hdr_mem[i] = 8'h00;
      clear_run_state();
      // register image after reset
      min_epoch_q = 64'd1;
      target_q = 32'd26;
      role_cfg_q = 32'd0;
      role_core_q = 32'd1;
      role_svc_q = 32'd2;
      cfg_max_q = 64'd65536;
      img_max_q = 64'd16777216;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_defaults_and_header_checks();
      test_entry_checks();
      test_size_limits();
      test_register_extremes();
      test_random(30, 75, 370);
      test_random(75, 30, 370);
      test_random(0, 0, 370);

      $display("covered %0d manifests, %0d bytes, %0d records checked", manifests_sent,
               bytes_sent, records_seen);
      $display("header, entry, size and register-extreme cases plus three idle mixes");
      if (errors == 0) begin
         $display("signed_manifest_header_parser_core regression: pass");
      end else begin
         $display("%0d mismatches", errors);
         $display("signed_manifest_header_parser_core regression: fail");
      end
      $finish;
   end
endmodule

### filelist.f
+incdir+hdl
hdl/smh_pkg.sv
hdl/smh_front.sv
hdl/smh_queue.sv
hdl/smh_back.sv
hdl/signed_manifest_header_parser_core.sv
bench/signed_manifest_header_parser_core_test.sv
